FILE: src/mtf_pkg.sv
// Package for the move-to-front lookup list: sizes, status codes and the command word type.
package mtf_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  // Command broadcast to every cell of the chain in the cycle a word is accepted.
  typedef struct packed {
    logic               add_go;
    logic               lookup_go;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

FILE: src/move_to_front_lookup_list.sv
// Top level of the move-to-front lookup list: cell chain, entry count and result register.
//
// A list of up to DEPTH (16) key/link entries held in a row of cells, front first. For each
// accepted word, all cells compare their key with the request at
// once, a priority signal ripples from the front to mark the first match, and on a hit
// every cell from the front to that match takes its neighbor's entry while the front cell
// takes the hit entry. An add writes the cell just past the last entry. The result is held
// in an output register, so a new word is accepted every cycle while the result side
// takes its words; in_stall rises only while a result waits under out_stall. Status is
// added, found, list empty, key not found or list full; found_link is zero unless found.
module move_to_front_lookup_list
  import mtf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VALUE_W-1:0] in_link_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic [VALUE_W-1:0] out_found_link
);

  logic               accept;
  logic               full;
  cmd_t               cmd;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [STAT_W-1:0]  status_r;
  logic [STAT_W-1:0]  status_nxt;
  logic [VALUE_W-1:0] link_r;
  logic [VALUE_W-1:0] link_nxt;

  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   first_hit;
  logic [DEPTH:0]     seen;
  logic [KEY_W-1:0]   cell_key   [DEPTH];
  logic [VALUE_W-1:0] cell_value [DEPTH];
  logic               hit_any;
  logic [VALUE_W-1:0] hit_value;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CNT_W'(DEPTH));

  assign cmd.add_go    = accept && (in_opcode == OP_ADD) && !full;
  assign cmd.lookup_go = accept && (in_opcode == OP_LOOKUP);
  assign cmd.key       = in_key;
  assign cmd.value     = in_link_value;

  assign seen[0] = 1'b0;
  assign hit_any = seen[DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_W-1:0]   prev_key;
      logic [VALUE_W-1:0] prev_value;
      if (gi == 0) begin : g_front
        // The hit entry's key equals the request key, so only its value needs selecting.
        assign prev_key   = in_key;
        assign prev_value = hit_value;
      end else begin : g_rest
        assign prev_key   = cell_key[gi-1];
        assign prev_value = cell_value[gi-1];
      end
      mtf_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (CNT_W'(gi) < cnt_r),
        .add_here   (CNT_W'(gi) == cnt_r),
        .seen_in    (seen[gi]),
        .hit_any    (hit_any),
        .prev_key   (prev_key),
        .prev_value (prev_value),
        .match      (match[gi]),
        .first_hit  (first_hit[gi]),
        .seen_out   (seen[gi+1]),
        .key_q      (cell_key[gi]),
        .value_q    (cell_value[gi])
      );
    end
  endgenerate

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_value = hit_value | (first_hit[i] ? cell_value[i] : '0);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.add_go) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = status_r;
    link_nxt   = link_r;
    if (accept) begin
      link_nxt = '0;
      if (in_opcode == OP_ADD) begin
        status_nxt = full ? ST_FULL : ST_ADDED;
      end else if (cnt_r == '0) begin
        status_nxt = ST_EMPTY;
      end else if (hit_any) begin
        status_nxt = ST_FOUND;
        link_nxt   = hit_value;
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    link_r   <= link_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_found_link = link_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds list depth");

  a_one_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_hit) && (hit_any == (first_hit != '0)) && ((first_hit & ~match) == '0))
    else $error("first-match priority chain is inconsistent");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_go |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("entry count did not advance on add");

  a_front_key: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.lookup_go && hit_any) |=> cell_key[0] == $past(in_key))
    else $error("hit entry was not moved to the front");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.lookup_go && hit_any) |=> (out_valid_r && status_r == ST_FOUND))
    else $error("hit did not produce a found result");
`endif

endmodule

FILE: src/mtf_cell.sv
// One list position: holds a key and its link value, compares and shifts toward the tail.
module mtf_cell
  import mtf_pkg::*;
(
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic               occupied,
  input  logic               add_here,
  input  logic               seen_in,
  input  logic               hit_any,
  input  logic [KEY_W-1:0]   prev_key,
  input  logic [VALUE_W-1:0] prev_value,
  output logic               match,
  output logic               first_hit,
  output logic               seen_out,
  output logic [KEY_W-1:0]   key_q,
  output logic [VALUE_W-1:0] value_q
);

  logic [KEY_W-1:0]   key_r;
  logic [KEY_W-1:0]   key_nxt;
  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;

  assign match     = occupied && (key_r == cmd.key);
  assign first_hit = match && !seen_in;
  assign seen_out  = seen_in || match;

  // Every cell from the front up to the hit takes its neighbor's entry; the front
  // cell's neighbor is the hit entry itself.
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (cmd.add_go && add_here) begin
      key_nxt   = cmd.key;
      value_nxt = cmd.value;
    end else if (cmd.lookup_go && hit_any && !seen_in) begin
      key_nxt   = prev_key;
      value_nxt = prev_value;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key_q   = key_r;
  assign value_q = value_r;

endmodule

FILE: tb/move_to_front_lookup_list_tb.sv
// Self-checking testbench for the move-to-front lookup list: directed, back-pressure and random tests.
`timescale 1ns / 1ps

module move_to_front_lookup_list_tb;
  import mtf_pkg::*;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] link;
  } list_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_opcode;
  logic [KEY_W-1:0]   in_key;
  logic [VALUE_W-1:0] in_link_value;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  out_status;
  logic [VALUE_W-1:0] out_found_link;

  // Mirror of the list contents, front entry at index 0.
  logic [KEY_W-1:0]   mirror_keys [DEPTH];
  logic [VALUE_W-1:0] mirror_links [DEPTH];
  int                 mirror_count;
  list_result_t       pending_results[$];

  int mismatch_count;
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold_req;

  move_to_front_lookup_list DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_key        (in_key),
    .in_link_value (in_link_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_found_link(out_found_link)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("move_to_front_lookup_list verification failed");
    $finish;
  end

  // Apply one accepted word to the mirror and queue the result it must produce.
  task automatic predict_list_op(input logic op, input logic [KEY_W-1:0] key,
                                 input logic [VALUE_W-1:0] link);
    list_result_t       res;
    int                 hit;
    int                 i;
    logic [KEY_W-1:0]   hit_key;
    logic [VALUE_W-1:0] hit_link;
    res.status = ST_ADDED;
    res.link   = '0;
    hit        = -1;
    if (op == OP_ADD) begin
      if (mirror_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        mirror_keys[mirror_count]  = key;
        mirror_links[mirror_count] = link;
        mirror_count++;
      end
    end else if (mirror_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // Scan from the tail so that the match nearest the front wins.
      for (i = mirror_count - 1; i >= 0; i--) begin
        if (mirror_keys[i] == key) hit = i;
      end
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        hit_key  = mirror_keys[hit];
        hit_link = mirror_links[hit];
        for (i = hit; i > 0; i--) begin
          mirror_keys[i]  = mirror_keys[i-1];
          mirror_links[i] = mirror_links[i-1];
        end
        mirror_keys[0]  = hit_key;
        mirror_links[0] = hit_link;
        res.status = ST_FOUND;
        res.link   = hit_link;
      end
    end
    pending_results.push_back(res);
  endtask

  // Valid stays high after acceptance; the next call either replaces the payload
  // in the same step or drops valid for its gap.
  task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] link);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_key        <= key;
    in_link_value <= link;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_list_op(op, key, link);
  endtask

  // Mostly keys held in the list at any depth, some misses and some extremes.
  function automatic logic [KEY_W-1:0] pick_lookup_key();
    int               r;
    logic [KEY_W-1:0] key;
    r   = $urandom_range(0, 99);
    key = KEY_W'($urandom);
    if (mirror_count > 0 && r >= 20) begin
      key = mirror_keys[$urandom_range(0, mirror_count - 1)];
    end else if (r >= 17) begin
      key = (r == 17) ? '0 : {KEY_W{1'b1}};
    end
    return key;
  endfunction

  task automatic test_empty_list();
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_LOOKUP, {KEY_W{1'b1}}, {VALUE_W{1'b1}});
  endtask

  task automatic test_add_and_lookup();
    send_word(OP_ADD, '0, '0);
    send_word(OP_ADD, {KEY_W{1'b1}}, {VALUE_W{1'b1}});
    send_word(OP_LOOKUP, {KEY_W{1'b1}}, '0);
    // A second lookup of the front entry must leave the order alone.
    send_word(OP_LOOKUP, {KEY_W{1'b1}}, 32'h5A5A_5A5A);
    send_word(OP_LOOKUP, 16'h1234, '0);
    send_word(OP_ADD, '0, 32'hA5A5_A5A5);
    send_word(OP_LOOKUP, '0, '0);
    send_word(OP_LOOKUP, '0, {VALUE_W{1'b1}});
  endtask

  task automatic test_random_growth();
    int               r;
    logic [KEY_W-1:0] key;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (mirror_count < DEPTH) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // A small key pool makes duplicate entries likely.
        key = (r < 30) ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom);
        send_word(OP_ADD, key, $urandom);
      end else begin
        send_word(OP_LOOKUP, pick_lookup_key(), $urandom);
      end
    end
  endtask

  task automatic test_full_list();
    send_word(OP_ADD, '0, {VALUE_W{1'b1}});
    send_word(OP_ADD, {KEY_W{1'b1}}, '0);
    send_word(OP_LOOKUP, mirror_keys[DEPTH-1], '0);
    send_word(OP_LOOKUP, mirror_keys[0], '0);
  endtask

  task automatic test_backpressure();
    int n;
    tx_idle_on    = 1'b0;
    long_hold_req = 1'b1;
    for (n = 0; n < 40; n++) begin
      send_word(n % 5 == 0 ? OP_ADD : OP_LOOKUP, pick_lookup_key(), $urandom);
    end
  endtask

  task automatic test_random_traffic();
    int n;
    for (n = 0; n < 1750; n++) begin
      // Switch idling on and off per stretch so both busy and sparse traffic occur.
      if (n % 100 == 0) begin
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 15) begin
        send_word(OP_ADD, KEY_W'($urandom), $urandom);
      end else begin
        send_word(OP_LOOKUP, pick_lookup_key(), $urandom);
      end
    end
  endtask

  // Receiver: random stall before each word, plus one long hold on request.
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = rx_idle_on ? $urandom_range(0, 17) : 0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = 300;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d, found_link %0h", out_status, out_found_link);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_status);
          mismatch_count++;
        end
        if (out_found_link !== exp_res.link) begin
          $error("found_link: expected %0h, actual %0h", exp_res.link, out_found_link);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_ADD;
    in_key        = '0;
    in_link_value = '0;
    mismatch_count = 0;
    mirror_count   = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    long_hold_req  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_add_and_lookup();
    test_random_growth();
    test_full_list();
    test_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("move_to_front_lookup_list verification clean");
    end else begin
      $display("move_to_front_lookup_list verification failed");
    end
    $finish;
  end

endmodule
